/* sv/central_face_flux_kernel_unit_assert.svh */
// Assertion macros shared by the face flux kernel RTL.
`ifndef CENTRAL_FACE_FLUX_KERNEL_UNIT_ASSERT_SVH
`define CENTRAL_FACE_FLUX_KERNEL_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define CFFK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define CFFK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/cffk_pkg.sv */
// Types, constants, micro-op table and arithmetic helpers for the face flux kernel.
package cffk_pkg;

  localparam int unsigned MAX_SPECIES = 8;
  localparam int unsigned FRAC_BITS   = 32;

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic               action;
    logic               line_start;
    logic signed [63:0] pressure;
    logic signed [63:0] velocity_x;
    logic signed [63:0] velocity_y;
    logic signed [63:0] velocity_z;
    logic signed [63:0] density;
    logic signed [63:0] total_energy;
    logic signed [63:0] face_normal_x;
    logic signed [63:0] face_normal_y;
    logic signed [63:0] face_normal_z;
    logic signed [63:0] mass_fraction;
  } in_beat_t;

  typedef struct packed {
    logic signed [63:0] flux_value;
    logic [3:0]         component;
    logic               last;
    logic               div_error;
  } out_beat_t;

  localparam logic ACT_CORE    = 1'b0;
  localparam logic ACT_SPECIES = 1'b1;

  localparam logic [3:0] REG_SPECIES_IN_USE = 4'd0;

  localparam logic [2:0] COMP_MASS   = 3'd0;
  localparam logic [2:0] COMP_MOM_X  = 3'd1;
  localparam logic [2:0] COMP_MOM_Y  = 3'd2;
  localparam logic [2:0] COMP_MOM_Z  = 3'd3;
  localparam logic [2:0] COMP_ENERGY = 3'd4;
  localparam int unsigned COMP_SPECIES_BASE = 5;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RUN, ST_WB} st_e;

  typedef enum logic [2:0] {OP_LD, OP_ADD, OP_SUB, OP_AVG, OP_HALF, OP_MUL, OP_DIV} op_e;

  // Scratch slots: loaded fields, carried state, temporaries, then species.
  localparam logic [5:0] S_P   = 6'd0;
  localparam logic [5:0] S_VX  = 6'd1;
  localparam logic [5:0] S_VY  = 6'd2;
  localparam logic [5:0] S_VZ  = 6'd3;
  localparam logic [5:0] S_D   = 6'd4;
  localparam logic [5:0] S_E   = 6'd5;
  localparam logic [5:0] S_NX  = 6'd6;
  localparam logic [5:0] S_NY  = 6'd7;
  localparam logic [5:0] S_NZ  = 6'd8;
  localparam logic [5:0] S_Y   = 6'd9;
  localparam logic [5:0] S_PP  = 6'd10;
  localparam logic [5:0] S_PVX = 6'd11;
  localparam logic [5:0] S_PVY = 6'd12;
  localparam logic [5:0] S_PVZ = 6'd13;
  localparam logic [5:0] S_PD  = 6'd14;
  localparam logic [5:0] S_PE  = 6'd15;
  localparam logic [5:0] S_FD  = 6'd16;
  localparam logic [5:0] S_FV  = 6'd17;
  localparam logic [5:0] S_ZERO = 6'd18;
  localparam logic [5:0] S_T0  = 6'd19;
  localparam logic [5:0] S_T1  = 6'd20;
  localparam logic [5:0] S_KC  = 6'd21;
  localparam logic [5:0] S_Q   = 6'd22;
  localparam logic [5:0] S_EN  = 6'd23;
  localparam logic [5:0] S_UFX = 6'd24;
  localparam logic [5:0] S_UFY = 6'd25;
  localparam logic [5:0] S_UFZ = 6'd26;
  localparam logic [5:0] S_U   = 6'd27;
  localparam logic [5:0] S_RHO = 6'd28;
  localparam logic [5:0] S_PF  = 6'd29;
  localparam logic [5:0] S_KE  = 6'd30;
  localparam logic [5:0] S_B   = 6'd31;
  localparam logic [5:0] S_C   = 6'd32;
  localparam logic [5:0] S_DVN = 6'd33;
  localparam logic [5:0] S_DPN = 6'd34;
  localparam int unsigned SPC_BASE = 35;

  localparam logic [6:0] PC_CORE    = 7'd0;
  localparam logic [6:0] PC_UPDATE  = 7'd67;
  localparam logic [6:0] PC_SPECIES = 7'd73;

  typedef struct packed {
    op_e        opc;
    logic [5:0] dst;
    logic [5:0] a;
    logic [5:0] b;
    logic       dst_spc;
    logic       b_spc;
    logic       emit;
    logic [2:0] comp;
    logic       last;
    logic       zchk;
    logic       br_ls;
    logic       fin;
  } uop_t;

  function automatic uop_t mk(input op_e opc, input logic [5:0] dst, input logic [5:0] a,
                              input logic [5:0] b);
    uop_t r;
    r = '0;
    r.opc = opc;
    r.dst = dst;
    r.a   = a;
    r.b   = b;
    return r;
  endfunction

  function automatic uop_t rom(input logic [6:0] pc);
    uop_t r;
    r = mk(OP_ADD, S_T0, S_ZERO, S_ZERO);
    case (pc)
      7'd0:  r = mk(OP_LD, S_P, S_ZERO, S_ZERO);
      7'd1:  r = mk(OP_LD, S_VX, S_ZERO, S_ZERO);
      7'd2:  r = mk(OP_LD, S_VY, S_ZERO, S_ZERO);
      7'd3:  r = mk(OP_LD, S_VZ, S_ZERO, S_ZERO);
      7'd4:  r = mk(OP_LD, S_D, S_ZERO, S_ZERO);
      7'd5:  r = mk(OP_LD, S_E, S_ZERO, S_ZERO);
      7'd6:  r = mk(OP_LD, S_NX, S_ZERO, S_ZERO);
      7'd7:  r = mk(OP_LD, S_NY, S_ZERO, S_ZERO);
      7'd8:  r = mk(OP_LD, S_NZ, S_ZERO, S_ZERO);
      7'd9:  r = mk(OP_MUL, S_T0, S_VX, S_VX);
      7'd10: r = mk(OP_MUL, S_T1, S_VY, S_VY);
      7'd11: r = mk(OP_ADD, S_T0, S_T0, S_T1);
      7'd12: r = mk(OP_MUL, S_T1, S_VZ, S_VZ);
      7'd13: r = mk(OP_ADD, S_T0, S_T0, S_T1);
      7'd14: r = mk(OP_HALF, S_KC, S_T0, S_ZERO);
      7'd15: r = mk(OP_DIV, S_Q, S_E, S_D);
      7'd16: begin
        r = mk(OP_SUB, S_EN, S_Q, S_KC);
        r.br_ls = 1'b1;
      end
      7'd17: r = mk(OP_AVG, S_UFX, S_VX, S_PVX);
      7'd18: r = mk(OP_AVG, S_UFY, S_VY, S_PVY);
      7'd19: r = mk(OP_AVG, S_UFZ, S_VZ, S_PVZ);
      7'd20: r = mk(OP_MUL, S_U, S_NX, S_UFX);
      7'd21: r = mk(OP_MUL, S_T0, S_NY, S_UFY);
      7'd22: r = mk(OP_ADD, S_U, S_U, S_T0);
      7'd23: r = mk(OP_MUL, S_T0, S_NZ, S_UFZ);
      7'd24: r = mk(OP_ADD, S_U, S_U, S_T0);
      7'd25: begin
        r = mk(OP_AVG, S_RHO, S_D, S_PD);
        r.zchk = 1'b1;
      end
      7'd26: r = mk(OP_AVG, S_PF, S_P, S_PP);
      7'd27: begin
        r = mk(OP_MUL, S_T0, S_RHO, S_U);
        r.emit = 1'b1;
        r.comp = COMP_MASS;
      end
      7'd28: r = mk(OP_MUL, S_T0, S_RHO, S_UFX);
      7'd29: r = mk(OP_MUL, S_T0, S_T0, S_U);
      7'd30: r = mk(OP_MUL, S_T1, S_PF, S_NX);
      7'd31: begin
        r = mk(OP_ADD, S_T0, S_T0, S_T1);
        r.emit = 1'b1;
        r.comp = COMP_MOM_X;
      end
      7'd32: r = mk(OP_MUL, S_T0, S_RHO, S_UFY);
      7'd33: r = mk(OP_MUL, S_T0, S_T0, S_U);
      7'd34: r = mk(OP_MUL, S_T1, S_PF, S_NY);
      7'd35: begin
        r = mk(OP_ADD, S_T0, S_T0, S_T1);
        r.emit = 1'b1;
        r.comp = COMP_MOM_Y;
      end
      7'd36: r = mk(OP_MUL, S_T0, S_RHO, S_UFZ);
      7'd37: r = mk(OP_MUL, S_T0, S_T0, S_U);
      7'd38: r = mk(OP_MUL, S_T1, S_PF, S_NZ);
      7'd39: begin
        r = mk(OP_ADD, S_T0, S_T0, S_T1);
        r.emit = 1'b1;
        r.comp = COMP_MOM_Z;
      end
      7'd40: r = mk(OP_AVG, S_KE, S_EN, S_PE);
      7'd41: r = mk(OP_MUL, S_B, S_VX, S_PVX);
      7'd42: r = mk(OP_MUL, S_C, S_VY, S_PVY);
      7'd43: r = mk(OP_ADD, S_B, S_B, S_C);
      7'd44: r = mk(OP_MUL, S_C, S_VZ, S_PVZ);
      7'd45: r = mk(OP_ADD, S_B, S_B, S_C);
      7'd46: r = mk(OP_HALF, S_B, S_B, S_ZERO);
      7'd47: r = mk(OP_ADD, S_KE, S_KE, S_B);
      7'd48: r = mk(OP_MUL, S_T0, S_RHO, S_KE);
      7'd49: r = mk(OP_MUL, S_T0, S_T0, S_U);
      7'd50: r = mk(OP_MUL, S_DVN, S_VX, S_NX);
      7'd51: r = mk(OP_MUL, S_C, S_VY, S_NY);
      7'd52: r = mk(OP_ADD, S_DVN, S_DVN, S_C);
      7'd53: r = mk(OP_MUL, S_C, S_VZ, S_NZ);
      7'd54: r = mk(OP_ADD, S_DVN, S_DVN, S_C);
      7'd55: r = mk(OP_MUL, S_DVN, S_PP, S_DVN);
      7'd56: r = mk(OP_MUL, S_DPN, S_PVX, S_NX);
      7'd57: r = mk(OP_MUL, S_C, S_PVY, S_NY);
      7'd58: r = mk(OP_ADD, S_DPN, S_DPN, S_C);
      7'd59: r = mk(OP_MUL, S_C, S_PVZ, S_NZ);
      7'd60: r = mk(OP_ADD, S_DPN, S_DPN, S_C);
      7'd61: r = mk(OP_MUL, S_DPN, S_P, S_DPN);
      7'd62: r = mk(OP_ADD, S_DVN, S_DVN, S_DPN);
      7'd63: r = mk(OP_HALF, S_DVN, S_DVN, S_ZERO);
      7'd64: begin
        r = mk(OP_ADD, S_T0, S_T0, S_DVN);
        r.emit = 1'b1;
        r.comp = COMP_ENERGY;
        r.last = 1'b1;
      end
      7'd65: r = mk(OP_ADD, S_FD, S_RHO, S_ZERO);
      7'd66: r = mk(OP_ADD, S_FV, S_U, S_ZERO);
      7'd67: r = mk(OP_ADD, S_PP, S_P, S_ZERO);
      7'd68: r = mk(OP_ADD, S_PVX, S_VX, S_ZERO);
      7'd69: r = mk(OP_ADD, S_PVY, S_VY, S_ZERO);
      7'd70: r = mk(OP_ADD, S_PVZ, S_VZ, S_ZERO);
      7'd71: r = mk(OP_ADD, S_PD, S_D, S_ZERO);
      7'd72: begin
        r = mk(OP_ADD, S_PE, S_EN, S_ZERO);
        r.fin = 1'b1;
      end
      7'd73: r = mk(OP_LD, S_Y, S_ZERO, S_ZERO);
      7'd74: begin
        r = mk(OP_AVG, S_T0, S_Y, 6'(SPC_BASE));
        r.b_spc = 1'b1;
      end
      7'd75: r = mk(OP_MUL, S_T0, S_FD, S_T0);
      7'd76: begin
        r = mk(OP_MUL, S_T0, S_T0, S_FV);
        r.emit = 1'b1;
        r.last = 1'b1;
      end
      7'd77: begin
        r = mk(OP_ADD, 6'(SPC_BASE), S_Y, S_ZERO);
        r.dst_spc = 1'b1;
        r.fin = 1'b1;
      end
      default: r.fin = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] half(input logic signed [63:0] a);
    return a >>> 1;
  endfunction

  function automatic logic signed [63:0] avg(input logic signed [63:0] a,
                                             input logic signed [63:0] b);
    return half(a) + half(b) + {63'd0, a[0] & b[0]};
  endfunction

  function automatic logic signed [63:0] from_sign_mag(input logic neg, input logic [63:0] m);
    if (!neg) return m[63] ? SMAX : m;
    if (m[63]) return SMIN;
    return -m;
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : a;
  endfunction

endpackage

/* sv/central_face_flux_kernel_unit.sv */
// Top level of the face flux kernel: micro-op sequencer over one shared arithmetic unit.
// Flow: a core beat runs the core program, a line-start core beat branches to the state
//   update, a species beat runs the species program; an over-limit species beat is taken and dropped.
// Throughput: one input beat at a time; the input stays stalled while the 128-step restoring
//   divider and the four-pass 32x32 multiplier of the shared unit run.
// Reset: asynchronous, active low; clears control, carried-state valid bits and the register.
`include "central_face_flux_kernel_unit_assert.svh"
module central_face_flux_kernel_unit #(
  parameter int unsigned MaxSpecies = cffk_pkg::MAX_SPECIES,
  parameter int unsigned FracBits   = cffk_pkg::FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cffk_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cffk_pkg::out_beat_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Species counter width covers 0..MaxSpecies; limit compare runs at least 4 bits wide.
  localparam int unsigned CW    = (MaxSpecies > 0) ? $clog2(MaxSpecies + 1) : 1;
  localparam int unsigned LW    = (CW > 4) ? CW : 4;
  localparam int unsigned Depth = cffk_pkg::SPC_BASE + MaxSpecies;
  localparam int unsigned AW    = $clog2(Depth + 1);
  localparam int unsigned NB    = cffk_pkg::SPC_BASE;

  // ---------------------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------------------
  logic [3:0] spc_in_use_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == {cffk_pkg::REG_SPECIES_IN_USE[0], 2'b00}) ? {28'd0, spc_in_use_q}
                                                                      : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_in_use_q <= '0;
    end else if (cfg_wr && paddr == {cffk_pkg::REG_SPECIES_IN_USE[0], 2'b00}) begin
      spc_in_use_q <= pwdata[3:0];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------------------
  cffk_pkg::st_e      state_q, state_d;
  logic [6:0]         pc_q;
  cffk_pkg::in_beat_t item_q;
  logic [CW-1:0]      spc_cnt_q;
  logic               face_valid_q;
  logic               derr_q;
  logic [6:0]         cnt_q;
  cffk_pkg::uop_t     uop;

  logic               in_acc;
  logic [LW-1:0]      spc_limit;
  logic               spc_full;
  logic               run_done;
  logic               emit_now;
  logic               wb_go;

  assign uop       = cffk_pkg::rom(pc_q);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign spc_limit = (LW'(spc_in_use_q) < LW'(MaxSpecies)) ? LW'(spc_in_use_q) : LW'(MaxSpecies);
  assign spc_full  = LW'(spc_cnt_q) >= spc_limit;
  // Species results go out only once a face exists.
  assign emit_now  = uop.emit && (item_q.action == cffk_pkg::ACT_CORE || face_valid_q);
  assign wb_go     = !(emit_now && out_valid_o && out_stall_i);

  // ---------------------------------------------------------------------------------------
  // Scratch memory: fields, carried state, temporaries and previous species fractions
  // ---------------------------------------------------------------------------------------
  logic signed [63:0] mem [Depth];
  logic [NB-1:0]      slot_valid_q;
  logic signed [63:0] rda_q, rdb_q;
  logic               va_q, vb_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      ra, rb, wa;
  logic signed [63:0] wr_data;
  logic signed [63:0] opa, opb;

  assign ra = AW'(uop.a);
  assign rb = AW'(uop.b) + (uop.b_spc ? AW'(spc_cnt_q) : AW'(0));
  assign wa = AW'(uop.dst) + (uop.dst_spc ? AW'(spc_cnt_q) : AW'(0));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wa] <= wr_data;
    end
    if (rd_en) begin
      rda_q <= mem[ra];
      rdb_q <= mem[rb];
      va_q  <= slot_valid_q[uop.a];
      vb_q  <= uop.b_spc ? 1'b1 : slot_valid_q[uop.b];
    end
  end

  // Unwritten carried-state slots read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (wr_en && !uop.dst_spc) begin
      slot_valid_q[uop.dst] <= 1'b1;
    end
  end

  assign opa = va_q ? rda_q : 64'sd0;
  assign opb = vb_q ? rdb_q : 64'sd0;

  // ---------------------------------------------------------------------------------------
  // Shared arithmetic unit: multi-pass multiplier and restoring divider
  // ---------------------------------------------------------------------------------------
  logic [63:0]  ma, mb;
  logic         neg;
  logic [63:0]  prod_q;
  logic [127:0] acc_q;
  logic [127:0] num_q, num_c;
  logic [63:0]  rem_q;
  logic [63:0]  quo_q;
  logic         over_q;
  logic [64:0]  rem2;
  logic         ge;
  logic [63:0]  part;
  logic [127:0] acc_add;

  assign ma    = cffk_pkg::magnitude(opa);
  assign mb    = cffk_pkg::magnitude(opb);
  assign neg   = opa[63] ^ opb[63];
  assign num_c = (cnt_q == 7'd0) ? (128'(ma) << FracBits) : num_q;
  assign rem2  = {rem_q, num_c[127]};
  assign ge    = rem2 >= {1'b0, mb};

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    part = 64'(ma[31:0])  * 64'(mb[31:0]);
      2'd1:    part = 64'(ma[31:0])  * 64'(mb[63:32]);
      2'd2:    part = 64'(ma[63:32]) * 64'(mb[31:0]);
      default: part = 64'(ma[63:32]) * 64'(mb[63:32]);
    endcase
  end

  always_comb begin
    case (cnt_q)
      7'd1:    acc_add = 128'(prod_q);
      7'd4:    acc_add = 128'(prod_q) << 64;
      default: acc_add = 128'(prod_q) << 32;
    endcase
  end

  assign run_done = (uop.opc == cffk_pkg::OP_MUL) ? (cnt_q == 7'd4)
                  : ((cnt_q == 7'd127) || (mb == 64'd0));

  always_ff @(posedge clk_i) begin
    if (state_q == cffk_pkg::ST_READ) begin
      acc_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      over_q <= 1'b0;
    end else if (state_q == cffk_pkg::ST_RUN) begin
      if (uop.opc == cffk_pkg::OP_MUL) begin
        if (cnt_q < 7'd4) begin
          prod_q <= part;
        end
        if (cnt_q != 7'd0) begin
          acc_q <= acc_q + acc_add;
        end
      end else begin
        // One quotient bit a cycle; bits above the Q range only flag overflow.
        rem_q <= ge ? 64'(rem2 - {1'b0, mb}) : rem2[63:0];
        num_q <= num_c << 1;
        quo_q <= {quo_q[62:0], ge};
        if (ge && cnt_q < 7'd64) begin
          over_q <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result of the current micro-op
  // ---------------------------------------------------------------------------------------
  logic signed [63:0] ld_val;
  logic signed [63:0] mul_res;
  logic signed [63:0] div_res;

  always_comb begin
    case (uop.dst)
      cffk_pkg::S_P:  ld_val = item_q.pressure;
      cffk_pkg::S_VX: ld_val = item_q.velocity_x;
      cffk_pkg::S_VY: ld_val = item_q.velocity_y;
      cffk_pkg::S_VZ: ld_val = item_q.velocity_z;
      cffk_pkg::S_D:  ld_val = item_q.density;
      cffk_pkg::S_E:  ld_val = item_q.total_energy;
      cffk_pkg::S_NX: ld_val = item_q.face_normal_x;
      cffk_pkg::S_NY: ld_val = item_q.face_normal_y;
      cffk_pkg::S_NZ: ld_val = item_q.face_normal_z;
      default:        ld_val = item_q.mass_fraction;
    endcase
  end

  assign mul_res = (|acc_q[127:64+FracBits]) ? (neg ? cffk_pkg::SMIN : cffk_pkg::SMAX)
                 : cffk_pkg::from_sign_mag(neg, acc_q[FracBits +: 64]);
  assign div_res = (mb == 64'd0) ? 64'sd0
                 : over_q ? (neg ? cffk_pkg::SMIN : cffk_pkg::SMAX)
                 : cffk_pkg::from_sign_mag(neg, quo_q);

  always_comb begin
    unique case (uop.opc)
      cffk_pkg::OP_LD:   wr_data = ld_val;
      cffk_pkg::OP_ADD:  wr_data = cffk_pkg::sat_add(opa, opb);
      cffk_pkg::OP_SUB:  wr_data = cffk_pkg::sat_sub(opa, opb);
      cffk_pkg::OP_AVG:  wr_data = cffk_pkg::avg(opa, opb);
      cffk_pkg::OP_HALF: wr_data = cffk_pkg::half(opa);
      cffk_pkg::OP_MUL:  wr_data = mul_res;
      default:           wr_data = div_res;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // State machine: next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cffk_pkg::ST_IDLE: begin
        if (in_acc && !(in_data_i.action == cffk_pkg::ACT_SPECIES && spc_full)) begin
          state_d = cffk_pkg::ST_READ;
        end
      end
      cffk_pkg::ST_READ: begin
        if (uop.opc == cffk_pkg::OP_MUL || uop.opc == cffk_pkg::OP_DIV) begin
          state_d = cffk_pkg::ST_RUN;
        end else begin
          state_d = cffk_pkg::ST_WB;
        end
      end
      cffk_pkg::ST_RUN: begin
        if (run_done) begin
          state_d = cffk_pkg::ST_WB;
        end
      end
      cffk_pkg::ST_WB: begin
        if (wb_go) begin
          state_d = uop.fin ? cffk_pkg::ST_IDLE : cffk_pkg::ST_READ;
        end
      end
      default: state_d = cffk_pkg::ST_IDLE;
    endcase
  end

  // State machine: outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    unique case (state_q)
      cffk_pkg::ST_IDLE: in_stall_o = 1'b0;
      cffk_pkg::ST_READ: rd_en      = 1'b1;
      cffk_pkg::ST_RUN:  rd_en      = 1'b0;
      cffk_pkg::ST_WB:   wr_en      = wb_go;
      default:           in_stall_o = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cffk_pkg::ST_IDLE;
      pc_q         <= cffk_pkg::PC_CORE;
      spc_cnt_q    <= '0;
      face_valid_q <= 1'b0;
      derr_q       <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == cffk_pkg::ST_RUN) begin
        cnt_q <= cnt_q + 7'd1;
      end else begin
        cnt_q <= '0;
      end
      if (in_acc) begin
        if (in_data_i.action == cffk_pkg::ACT_SPECIES) begin
          pc_q <= cffk_pkg::PC_SPECIES;
        end else begin
          // A core beat restarts the species walk; a line start drops the face.
          pc_q         <= cffk_pkg::PC_CORE;
          spc_cnt_q    <= '0;
          derr_q       <= 1'b0;
          face_valid_q <= !in_data_i.line_start;
        end
      end
      if (state_q == cffk_pkg::ST_WB && wb_go) begin
        if (uop.zchk && (opa == 64'sd0 || opb == 64'sd0)) begin
          derr_q <= 1'b1;
        end
        if (uop.fin) begin
          if (item_q.action == cffk_pkg::ACT_SPECIES) begin
            spc_cnt_q <= spc_cnt_q + CW'(1);
          end
        end else if (uop.br_ls && item_q.line_start) begin
          pc_q <= cffk_pkg::PC_UPDATE;
        end else begin
          pc_q <= pc_q + 7'd1;
        end
      end
    end
  end

  // Hold the accepted beat for the whole program.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register: one result beat waits here while the sequencer moves on
  // ---------------------------------------------------------------------------------------
  logic                out_valid_q;
  cffk_pkg::out_beat_t out_q;
  logic                emit_fire;

  assign emit_fire = state_q == cffk_pkg::ST_WB && wb_go && emit_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.flux_value <= wr_data;
      out_q.last       <= uop.last;
      if (item_q.action == cffk_pkg::ACT_SPECIES) begin
        out_q.component <= 4'(32'(spc_cnt_q) + cffk_pkg::COMP_SPECIES_BASE);
        out_q.div_error <= 1'b0;
      end else begin
        out_q.component <= {1'b0, uop.comp};
        out_q.div_error <= derr_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  `CFFK_ASSERT_ALWAYS(a_zero_slot_kept, !(wr_en && !uop.dst_spc && uop.dst == cffk_pkg::S_ZERO), "zero slot written")
  `CFFK_ASSERT_ALWAYS(a_spc_cnt_bound, LW'(spc_cnt_q) <= LW'(MaxSpecies), "species counter overrun")
  `CFFK_ASSERT_NEXT(a_line_start_drop, in_acc && in_data_i.action == cffk_pkg::ACT_CORE && in_data_i.line_start, !face_valid_q, "face kept after line start")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the central face flux kernel unit.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 600;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  cffk_pkg::in_beat_t    in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  cffk_pkg::out_beat_t   out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  central_face_flux_kernel_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Cells waiting to be driven, and flux beats still owed by the block.
  cffk_pkg::in_beat_t  cell_q[$];
  cffk_pkg::out_beat_t flux_q[$];
  int unsigned errs;
  bit          idle_en;

  // Predictor copy of the block state and its register.
  logic [3:0]         species_limit_reg;
  logic signed [63:0] last_p, last_d, last_e, face_rho, face_u;
  logic signed [63:0] last_v[3];
  logic signed [63:0] last_spc[cffk_pkg::MAX_SPECIES];
  int unsigned        spc_count;
  bit                 face_ok;

  // Generator-side shadow: keeps species items from reading entries never written.
  int unsigned gen_count, gen_limit;
  bit          gen_face;
  bit [cffk_pkg::MAX_SPECIES-1:0] gen_written;

  // ---------------------------------------------------------------- Q32.32 arithmetic
  function automatic logic signed [63:0] q_clamp(input bit neg, input logic [63:0] m);
    if (!neg) return m[63] ? cffk_pkg::SMAX : m;
    return m[63] ? cffk_pkg::SMIN : -$signed(m);
  endfunction

  function automatic logic [63:0] q_mag(input logic signed [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(cffk_pkg::SMAX)) return cffk_pkg::SMAX;
    if (s < 65'(cffk_pkg::SMIN)) return cffk_pkg::SMIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] q_sub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(cffk_pkg::SMAX)) return cffk_pkg::SMAX;
    if (s < 65'(cffk_pkg::SMIN)) return cffk_pkg::SMIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] q_half(input logic signed [63:0] a);
    return {a[63], a[63:1]};
  endfunction

  // Exact midpoint, rounded toward minus infinity.
  function automatic logic signed [63:0] q_avg(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    return s[64:1];
  endfunction

  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [127:0] prod;
    bit neg;
    prod = {64'd0, q_mag(a)} * {64'd0, q_mag(b)};
    neg = a[63] ^ b[63];
    if (prod[127:96] != 0) return neg ? cffk_pkg::SMIN : cffk_pkg::SMAX;
    return q_clamp(neg, prod[95:32]);
  endfunction

  function automatic logic signed [63:0] q_div(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [127:0] quo;
    bit neg;
    quo = {32'd0, q_mag(a), 32'd0} / {64'd0, q_mag(b)};
    neg = a[63] ^ b[63];
    if (quo[127:64] != 0) return neg ? cffk_pkg::SMIN : cffk_pkg::SMAX;
    return q_clamp(neg, quo[63:0]);
  endfunction

  function automatic logic signed [63:0] q_dot(input logic signed [63:0] x0, x1, x2,
                                               input logic signed [63:0] y0, y1, y2);
    return q_add(q_add(q_mul(x0, y0), q_mul(x1, y1)), q_mul(x2, y2));
  endfunction

  // ---------------------------------------------------------------- flux predictor
  task automatic flux_predict(input cffk_pkg::in_beat_t c);
    logic signed [63:0] vel[3], nrm[3], uf[3];
    logic signed [63:0] kin, e, ke, rho, pf, u, f;
    logic signed [63:0] res[5];
    cffk_pkg::out_beat_t b;
    int unsigned lim, n;
    bit derr;
    if (c.action == cffk_pkg::ACT_SPECIES) begin
      lim = (species_limit_reg < cffk_pkg::MAX_SPECIES) ? species_limit_reg
                                                        : cffk_pkg::MAX_SPECIES;
      n = spc_count;
      if (n >= lim) return;
      f = q_mul(q_mul(face_rho, q_avg(c.mass_fraction, last_spc[n])), face_u);
      last_spc[n] = c.mass_fraction;
      spc_count = n + 1;
      if (!face_ok) return;
      b.flux_value = f;
      b.component  = 4'(cffk_pkg::COMP_SPECIES_BASE + n);
      b.last       = 1'b1;
      b.div_error  = 1'b0;
      flux_q.push_back(b);
      return;
    end
    vel[0] = c.velocity_x; vel[1] = c.velocity_y; vel[2] = c.velocity_z;
    nrm[0] = c.face_normal_x; nrm[1] = c.face_normal_y; nrm[2] = c.face_normal_z;
    kin = q_half(q_dot(vel[0], vel[1], vel[2], vel[0], vel[1], vel[2]));
    // Zero density: take the energy quotient as zero and flag the face.
    e = q_sub((c.density != 0) ? q_div(c.total_energy, c.density) : 64'sd0, kin);
    derr = (c.density == 0) || (last_d == 0);
    spc_count = 0;
    if (c.line_start) begin
      face_ok = 1'b0;
    end else begin
      for (int k = 0; k < 3; k++) uf[k] = q_avg(vel[k], last_v[k]);
      u   = q_dot(nrm[0], nrm[1], nrm[2], uf[0], uf[1], uf[2]);
      rho = q_avg(c.density, last_d);
      pf  = q_avg(c.pressure, last_p);
      res[0] = q_mul(rho, u);
      for (int k = 0; k < 3; k++)
        res[1 + k] = q_add(q_mul(q_mul(rho, uf[k]), u), q_mul(pf, nrm[k]));
      ke = q_add(q_avg(e, last_e),
                 q_half(q_dot(vel[0], vel[1], vel[2], last_v[0], last_v[1], last_v[2])));
      res[4] = q_add(q_mul(q_mul(rho, ke), u),
                     q_half(q_add(
                       q_mul(last_p, q_dot(vel[0], vel[1], vel[2], nrm[0], nrm[1], nrm[2])),
                       q_mul(c.pressure,
                             q_dot(last_v[0], last_v[1], last_v[2], nrm[0], nrm[1], nrm[2])))));
      face_rho = rho;
      face_u   = u;
      face_ok  = 1'b1;
    end
    last_p = c.pressure;
    for (int k = 0; k < 3; k++) last_v[k] = vel[k];
    last_d = c.density;
    last_e = e;
    if (!face_ok) return;
    for (int k = 0; k < 5; k++) begin
      b.flux_value = res[k];
      b.component  = 4'(k);
      b.last       = (k == cffk_pkg::COMP_ENERGY);
      b.div_error  = derr;
      flux_q.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------- clock, reset, limit
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned cycles;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- input driver
  int unsigned in_gap;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      // Predict on the beat the block takes at this edge.
      if (in_valid_i && !in_stall_o) flux_predict(in_data_i);
      // Hold the payload while stalled; otherwise advance or idle.
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap == 0 && idle_en && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 10);
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (cell_q.size() > 0) begin
          in_data_i  <= cell_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- output monitor
  int unsigned out_gap;
  always @(posedge clk_i) begin
    cffk_pkg::out_beat_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (flux_q.size() == 0) begin
          $display("%0t: unexpected flux beat %p", $time, out_data_o);
          errs++;
        end else begin
          want = flux_q.pop_front();
          if (out_data_o.flux_value !== want.flux_value) begin
            $display("%0t: flux_value expected %h actual %h", $time, want.flux_value,
                     out_data_o.flux_value);
            errs++;
          end
          if (out_data_o.component !== want.component) begin
            $display("%0t: component expected %0d actual %0d", $time, want.component,
                     out_data_o.component);
            errs++;
          end
          if (out_data_o.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, out_data_o.last);
            errs++;
          end
          if (out_data_o.div_error !== want.div_error) begin
            $display("%0t: div_error expected %b actual %b", $time, want.div_error,
                     out_data_o.div_error);
            errs++;
          end
        end
      end
      // Stall the result side in bursts.
      if (out_gap == 0 && idle_en && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 10);
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic signed [63:0] rand_q();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0:       return 64'sd0;
      1:       return cffk_pkg::SMAX;
      2:       return cffk_pkg::SMIN;
      3, 4:    return r;
      5:       return r[0] ? -64'sh1_0000_0000 : 64'sh1_0000_0000;
      default: return $signed(r) >>> 26;
    endcase
  endfunction

  function automatic cffk_pkg::in_beat_t cell_all(input logic ls, input logic signed [63:0] v);
    cffk_pkg::in_beat_t c;
    c.action = cffk_pkg::ACT_CORE;
    c.line_start = ls;
    c.pressure = v; c.velocity_x = v; c.velocity_y = v; c.velocity_z = v;
    c.density = v; c.total_energy = v;
    c.face_normal_x = v; c.face_normal_y = v; c.face_normal_z = v;
    c.mass_fraction = v;
    return c;
  endfunction

  function automatic cffk_pkg::in_beat_t cell_rand(input logic ls);
    cffk_pkg::in_beat_t c;
    c.action = cffk_pkg::ACT_CORE;
    c.line_start = ls;
    c.pressure = rand_q(); c.velocity_x = rand_q(); c.velocity_y = rand_q();
    c.velocity_z = rand_q(); c.total_energy = rand_q();
    c.density = ($urandom_range(0, 9) == 0) ? 64'sd0 : rand_q();
    c.face_normal_x = rand_q(); c.face_normal_y = rand_q(); c.face_normal_z = rand_q();
    c.mass_fraction = rand_q();
    return c;
  endfunction

  function automatic cffk_pkg::in_beat_t species_beat(input logic signed [63:0] y);
    cffk_pkg::in_beat_t c;
    c = cell_rand(1'($urandom_range(0, 1)));
    c.action = cffk_pkg::ACT_SPECIES;
    c.mass_fraction = y;
    return c;
  endfunction

  // Queue a beat; drop a species beat that would read an entry never written.
  task automatic queue_beat(input cffk_pkg::in_beat_t c, inout int unsigned count);
    if (c.action == cffk_pkg::ACT_SPECIES) begin
      if (gen_count < gen_limit) begin
        if (gen_face && !gen_written[gen_count]) return;
        gen_written[gen_count] = 1'b1;
        gen_count++;
      end
    end else begin
      gen_count = 0;
      gen_face  = !c.line_start;
    end
    cell_q.push_back(c);
    count++;
  endtask

  task automatic write_species_limit(input logic [3:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'({cffk_pkg::REG_SPECIES_IN_USE, 2'b00});
    pwdata  <= {28'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    species_limit_reg = v;
    gen_limit = (v < cffk_pkg::MAX_SPECIES) ? v : cffk_pkg::MAX_SPECIES;
  endtask

  // Wait out all traffic, then the longest silent beat, before touching the register.
  task automatic drain_block();
    while (cell_q.size() > 0 || in_valid_i || flux_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    logic [3:0] limits[6];
    int unsigned count, nspc;
    limits = '{4'd2, 4'd8, 4'd15, 4'd0, 4'd5, 4'd1};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errs = 0; cycles = 0; in_gap = 0; out_gap = 0; idle_en = 1'b1;
    species_limit_reg = '0;
    last_p = 0; last_d = 0; last_e = 0; face_rho = 0; face_u = 0;
    for (int k = 0; k < 3; k++) last_v[k] = 0;
    for (int k = 0; k < cffk_pkg::MAX_SPECIES; k++) last_spc[k] = 0;
    spc_count = 0; face_ok = 1'b0;
    gen_count = 0; gen_limit = 0; gen_face = 1'b0; gen_written = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      write_species_limit(limits[ph]);
      if (ph == 5) idle_en = 1'b0;
      count = 0;
      if (ph == 0) begin
        // Directed: face from reset state, species load then flux, overflow species,
        // zero density, saturating extremes.
        queue_beat(cell_rand(1'b0), count);
        queue_beat(cell_all(1'b1, 64'sh2_0000_0000), count);
        queue_beat(species_beat(64'sh0_8000_0000), count);
        queue_beat(species_beat(cffk_pkg::SMAX), count);
        queue_beat(species_beat(cffk_pkg::SMIN), count);
        queue_beat(cell_all(1'b0, 64'sh1_8000_0000), count);
        queue_beat(species_beat(cffk_pkg::SMIN), count);
        queue_beat(species_beat(cffk_pkg::SMAX), count);
        queue_beat(species_beat(64'sd0), count);
        queue_beat(cell_all(1'b0, 64'sd0), count);
        queue_beat(cell_all(1'b0, cffk_pkg::SMAX), count);
        queue_beat(cell_all(1'b0, cffk_pkg::SMIN), count);
        queue_beat(cell_all(1'b0, -64'sd1), count);
        queue_beat(cell_all(1'b0, 64'sd1), count);
        queue_beat(cell_all(1'b1, cffk_pkg::SMIN), count);
        queue_beat(species_beat(-64'sd1), count);
        queue_beat(cell_all(1'b0, 64'sh3_0000_0000), count);
        queue_beat(species_beat(64'sd1), count);
        queue_beat(species_beat(64'sh4_0000_0000), count);
      end
      // Random lines: mostly full cells with their species, some noise beats.
      while (count < 34) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_beat(species_beat(rand_q()), count);
        end else begin
          queue_beat(cell_rand(($urandom_range(0, 7) == 0) || gen_limit > 0 && !gen_face),
                     count);
          nspc = $urandom_range(0, gen_limit + 1);
          for (int s = 0; s < nspc; s++) queue_beat(species_beat(rand_q()), count);
        end
      end
      drain_block();
    end

    if (errs == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
